FILE: hdl/ljpf_pkg.sv
// Shared types and constants for the Lennard-Jones pair force accumulator.
// No dependencies; every other file but ljpf_mulq imports this package.
package ljpf_pkg;

  localparam int IDX_W = 13;
  localparam int POS_W = 24;
  localparam int FRC_W = 32;
  localparam int SUM_W = 48;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 32;

  localparam int NUM_PARTICLES_DEF = 8192;
  localparam int QUEUE_DEPTH = 4;

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_PAIR  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_CUT  = 2'd2;
  localparam logic [1:0] STAT_SAT  = 2'd3;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_BOX    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_INVSIG = 2'd1;
  localparam logic [CFG_IW-1:0] REG_CUTOFF = 2'd2;
  localparam logic [CFG_IW-1:0] REG_EPS    = 2'd3;

  localparam logic [23:0] BOX_RST    = 24'd13107200;
  localparam logic [31:0] INVSIG_RST = 32'd10737418;
  localparam logic [31:0] CUTOFF_RST = 32'd1966080;
  localparam logic [23:0] EPS_RST    = 24'd65536;

  typedef struct packed {
    logic [23:0] box_length;
    logic [31:0] inv_sigma_sq;
    logic [31:0] cutoff_r2;
    logic [23:0] bind_energy;
  } ljpf_cfg_t;

  // classified command as it sits in the queue
  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic             zero;
    logic             neg_x;
    logic             neg_y;
    logic [POS_W-1:0] adx;
    logic [POS_W-1:0] ady;
  } ljpf_item_t;

  typedef enum logic [3:0] {
    BS_INIT,
    BS_IDLE,
    BS_CLR,
    BS_READ,
    BS_READ_W,
    BS_MSTART,
    BS_MWAIT,
    BS_CUT,
    BS_DIV,
    BS_RDA,
    BS_WRA,
    BS_RDB,
    BS_WRB,
    BS_ACC,
    BS_DONE
  } ljpf_bstate_t;

endpackage

FILE: hdl/ljpf_if.sv
// Channel interfaces: command items, results and the register write port.
// Depends on ljpf_pkg.
interface ljpf_item_if import ljpf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic [IDX_W-1:0] index_a;
  logic [IDX_W-1:0] index_b;
  logic [POS_W-1:0] pos_ax;
  logic [POS_W-1:0] pos_ay;
  logic [POS_W-1:0] pos_bx;
  logic [POS_W-1:0] pos_by;

  modport source (output valid, cmd, index_a, index_b, pos_ax, pos_ay, pos_bx, pos_by,
                  input ready);
  modport sink (input valid, cmd, index_a, index_b, pos_ax, pos_ay, pos_bx, pos_by,
                output ready);
endinterface

interface ljpf_result_if import ljpf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic signed [FRC_W-1:0] force_x;
  logic signed [FRC_W-1:0] force_y;
  logic signed [SUM_W-1:0] energy_sum;
  logic signed [SUM_W-1:0] virial_sum;

  modport source (output valid, status, force_x, force_y, energy_sum, virial_sum,
                  input ready);
  modport sink (input valid, status, force_x, force_y, energy_sum, virial_sum,
                output ready);
endinterface

interface ljpf_cfg_if import ljpf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] reg_index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

FILE: hdl/ljpf_front.sv
// Front end: takes command transactions, forms the minimum-image separation,
// flags a zero separation on either axis and hands a classified entry to the queue. Uses ljpf_pkg.
module ljpf_front import ljpf_pkg::*; (
  ljpf_item_if.sink  items,
  input  logic [23:0] box_length,
  input  logic        hold,
  input  logic        push_ready,
  output logic        push_valid,
  output ljpf_item_t  push_item
);

  logic signed [26:0] dxr, dyr, dxw, dyw, adx_w, ady_w;

  function automatic logic signed [26:0] wrap(input logic signed [26:0] d,
                                              input logic [23:0] l);
    logic signed [26:0] ls;
    logic signed [26:0] d2;
    begin
      ls = $signed({3'b000, l});
      d2 = d <<< 1;
      if (d2 > ls) begin
        wrap = d - ls;
      end else if (d2 < -ls) begin
        wrap = d + ls;
      end else begin
        wrap = d;
      end
    end
  endfunction

  always_comb begin
    dxr   = $signed({3'b000, items.pos_ax}) - $signed({3'b000, items.pos_bx});
    dyr   = $signed({3'b000, items.pos_ay}) - $signed({3'b000, items.pos_by});
    dxw   = wrap(dxr, box_length);
    dyw   = wrap(dyr, box_length);
    adx_w = dxw[26] ? -dxw : dxw;
    ady_w = dyw[26] ? -dyw : dyw;

    push_item.cmd   = items.cmd;
    push_item.idx_a = items.index_a;
    push_item.idx_b = items.index_b;
    push_item.zero  = (dxr == 27'sd0) || (dyr == 27'sd0);
    push_item.neg_x = dxw[26];
    push_item.neg_y = dyw[26];
    push_item.adx   = adx_w[POS_W-1:0];
    push_item.ady   = ady_w[POS_W-1:0];
  end

  assign items.ready = push_ready && !hold;
  assign push_valid  = items.valid && !hold;

endmodule

FILE: hdl/ljpf_queue.sv
// Short FIFO between front end and back end.
// Uses ljpf_pkg for the entry type.
module ljpf_queue import ljpf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  ljpf_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output ljpf_item_t pop_item
);

  localparam int PW = $clog2(DEPTH);

  ljpf_item_t     slots [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [PW:0]    count;
  logic           do_push, do_pop;

  assign push_ready = (count != (PW+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/ljpf_mulq.sv
// Fixed-point multiplier floor(a*b/2^32), saturating at 2^61, built from four
// 32x32 partial products taken one a cycle. Standalone, no package use.
module ljpf_mulq (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [61:0] res,
  output logic        sat
);

  localparam logic [66:0] SATV = 67'd1 << 61;

  logic [63:0] ra, rb, p;
  logic [1:0]  pk;
  logic        pv, busy, sath;
  logic [2:0]  cnt;
  logic [66:0] acc, addend;
  logic [31:0] op_a, op_b;
  logic        over;

  // partial product order: al*bl, ah*bl, al*bh, ah*bh
  assign op_a = cnt[0] ? ra[63:32] : ra[31:0];
  assign op_b = cnt[1] ? rb[63:32] : rb[31:0];

  always_comb begin
    case (pk)
      2'd0:    addend = 67'(p[63:32]);
      2'd3:    addend = 67'({p[29:0], 32'd0});
      default: addend = 67'(p);
    endcase
  end

  assign over = acc > SATV;
  assign res  = (over || sath) ? SATV[61:0] : acc[61:0];
  assign sat  = sath || over;
  assign done = busy && (cnt == 3'd4) && !pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pv   <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      ra   <= a;
      rb   <= b;
      busy <= 1'b1;
      cnt  <= '0;
      acc  <= '0;
      sath <= 1'b0;
      pv   <= 1'b0;
    end else if (busy) begin
      if (cnt != 3'd4) begin
        p   <= {32'd0, op_a} * {32'd0, op_b};
        pk  <= cnt[1:0];
        pv  <= 1'b1;
        cnt <= cnt + 1'b1;
      end else begin
        pv <= 1'b0;
      end
      if (pv) begin
        acc <= acc + addend;
        // high product of 2^30 or more already means saturation
        if (pk == 2'd3) begin
          sath <= |p[63:30];
        end
      end
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/ljpf_back.sv
// Back end: sequencer over the shared multiplier and a bit-serial divider,
// force store RAM with read-modify-write, sums and result register. Uses ljpf_pkg.
module ljpf_back import ljpf_pkg::*; #(
  parameter int NUM_PARTICLES = NUM_PARTICLES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  ljpf_cfg_t     cfg_regs,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  ljpf_item_t    pop_item,
  output logic          init_busy,
  ljpf_result_if.source results
);

  localparam int DEPTH = (NUM_PARTICLES < (1 << IDX_W)) ? NUM_PARTICLES : (1 << IDX_W);
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    MS_DX2, MS_DY2, MS_R2, MS_U2, MS_U3, MS_U4, MS_U6, MS_U7,
    MS_VE, MS_M, MS_DFM, MS_FX, MS_FY, MS_VIR
  } ljpf_mstep_t;

  ljpf_bstate_t state, state_next;
  ljpf_mstep_t  step;
  ljpf_item_t   cur;

  logic [AW-1:0] clr_addr;
  logic          clr_last;

  logic [48:0] d2, u;
  logic [38:0] r2;
  logic [61:0] u2, u3, u4, u6, u7, ve, mm, dfm, fxm, fym, virm;
  logic [31:0] div_rem, dvs;
  logic [5:0]  div_cnt;
  logic [32:0] rem_sh;
  logic        div_ge;

  logic        sat;
  logic [1:0]  stat;
  logic signed [31:0] rfx, rfy;
  logic signed [47:0] energy, virial;

  logic        out_valid, out_load;
  logic [1:0]  out_status;
  logic signed [31:0] out_fx, out_fy;
  logic signed [47:0] out_e, out_v;

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data, mem_wdata;
  logic [AW-1:0] mem_addr;
  logic        mem_we;

  logic        mul_start, mul_done, mul_sat;
  logic [63:0] mul_a, mul_b;
  logic [61:0] mul_res;

  logic        a_ok, b_ok, eneg, gneg, negx, negy;
  logic [62:0] e_diff;
  logic [61:0] g_diff;
  logic [27:0] eps12;
  logic signed [63:0] fxs, fys, fdx, fdy, old_x, old_y, sum_x, sum_y;
  logic signed [63:0] vij, vir, sum_e, sum_v;
  logic signed [63:0] clp_x, clp_y, clp_e, clp_v;
  logic        ovf_x, ovf_y, ovf_e, ovf_v;

  function automatic logic idx_ok(input logic [IDX_W-1:0] i);
    return ({{(32-IDX_W){1'b0}}, i} < 32'(NUM_PARTICLES));
  endfunction

  function automatic logic ovf(input logic signed [63:0] v, input int bits);
    logic signed [63:0] hi;
    begin
      hi  = (64'sd1 <<< (bits - 1)) - 64'sd1;
      ovf = (v > hi) || (v < -hi - 64'sd1);
    end
  endfunction

  function automatic logic signed [63:0] clip(input logic signed [63:0] v, input int bits);
    logic signed [63:0] hi;
    begin
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      if (v > hi) begin
        clip = hi;
      end else if (v < -hi - 64'sd1) begin
        clip = -hi - 64'sd1;
      end else begin
        clip = v;
      end
    end
  endfunction

  ljpf_mulq u_mulq (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res),
    .sat   (mul_sat)
  );

  // ---------------------------------------------------------------- datapath terms
  always_comb begin
    a_ok     = idx_ok(cur.idx_a);
    b_ok     = idx_ok(cur.idx_b);
    clr_last = (clr_addr == AW'(DEPTH-1));
    eneg     = {1'b0, u6} < {u3, 1'b0};
    e_diff   = eneg ? ({u3, 1'b0} - {1'b0, u6}) : ({1'b0, u6} - {u3, 1'b0});
    gneg     = u7 < u4;
    g_diff   = gneg ? (u4 - u7) : (u7 - u4);
    eps12    = ({4'd0, cfg_regs.bind_energy} << 3) + ({4'd0, cfg_regs.bind_energy} << 2);
    negx     = gneg ^ cur.neg_x;
    negy     = gneg ^ cur.neg_y;
    fxs      = negx ? -$signed({2'b00, fxm}) : $signed({2'b00, fxm});
    fys      = negy ? -$signed({2'b00, fym}) : $signed({2'b00, fym});
    fdx      = (state == BS_WRB) ? -fxs : fxs;
    fdy      = (state == BS_WRB) ? -fys : fys;
    old_x    = $signed({{32{rd_data[31]}}, rd_data[31:0]});
    old_y    = $signed({{32{rd_data[63]}}, rd_data[63:32]});
    sum_x    = old_x + fdx;
    sum_y    = old_y + fdy;
    ovf_x    = ovf(sum_x, FRC_W);
    ovf_y    = ovf(sum_y, FRC_W);
    clp_x    = clip(sum_x, FRC_W);
    clp_y    = clip(sum_y, FRC_W);
    vij      = eneg ? -$signed({2'b00, ve}) : $signed({2'b00, ve});
    vir      = gneg ? -$signed({2'b00, virm}) : $signed({2'b00, virm});
    sum_e    = $signed({{16{energy[47]}}, energy}) + vij;
    sum_v    = $signed({{16{virial[47]}}, virial}) + vir;
    ovf_e    = ovf(sum_e, SUM_W);
    ovf_v    = ovf(sum_v, SUM_W);
    clp_e    = clip(sum_e, SUM_W);
    clp_v    = clip(sum_v, SUM_W);
    rem_sh   = {div_rem, (div_cnt == 6'd48)};
    div_ge   = rem_sh >= {1'b0, dvs};
  end

  // multiplier operand selection by sequencer step
  always_comb begin
    case (step)
      MS_DX2: begin mul_a = {8'd0, cur.adx, 32'd0}; mul_b = 64'(cur.adx); end
      MS_DY2: begin mul_a = {8'd0, cur.ady, 32'd0}; mul_b = 64'(cur.ady); end
      MS_R2:  begin mul_a = 64'(d2);  mul_b = 64'(cfg_regs.inv_sigma_sq); end
      MS_U2:  begin mul_a = 64'(u);   mul_b = 64'(u);  end
      MS_U3:  begin mul_a = 64'(u2);  mul_b = 64'(u);  end
      MS_U4:  begin mul_a = 64'(u2);  mul_b = 64'(u2); end
      MS_U6:  begin mul_a = 64'(u3);  mul_b = 64'(u3); end
      MS_U7:  begin mul_a = 64'(u6);  mul_b = 64'(u);  end
      MS_VE:  begin mul_a = 64'(cfg_regs.bind_energy); mul_b = 64'(e_diff); end
      MS_M:   begin mul_a = 64'(eps12); mul_b = 64'(g_diff); end
      MS_DFM: begin mul_a = 64'(mm);  mul_b = 64'(cfg_regs.inv_sigma_sq); end
      MS_FX:  begin mul_a = 64'(dfm); mul_b = {21'd0, cur.adx, 19'd0}; end
      MS_FY:  begin mul_a = 64'(dfm); mul_b = {21'd0, cur.ady, 19'd0}; end
      MS_VIR: begin mul_a = 64'(dfm); mul_b = {9'd0, d2, 6'd0}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      BS_INIT: if (clr_last) state_next = BS_IDLE;
      BS_IDLE: begin
        if (pop_valid) begin
          case (pop_item.cmd)
            CMD_CLEAR: state_next = BS_CLR;
            CMD_PAIR:  state_next = pop_item.zero ? BS_DONE : BS_MSTART;
            CMD_READ:  state_next = idx_ok(pop_item.idx_a) ? BS_READ : BS_DONE;
            default:   state_next = BS_DONE;
          endcase
        end
      end
      BS_CLR:    if (clr_last) state_next = BS_DONE;
      BS_READ:   state_next = BS_READ_W;
      BS_READ_W: state_next = BS_DONE;
      BS_MSTART: state_next = BS_MWAIT;
      BS_MWAIT: begin
        if (mul_done) begin
          if (step == MS_R2) begin
            state_next = BS_CUT;
          end else if (step == MS_VIR) begin
            state_next = a_ok ? BS_RDA : (b_ok ? BS_RDB : BS_ACC);
          end else begin
            state_next = BS_MSTART;
          end
        end
      end
      BS_CUT:  state_next = (r2 >= {7'd0, cfg_regs.cutoff_r2}) ? BS_DONE : BS_DIV;
      BS_DIV:  if (div_cnt == 6'd0) state_next = BS_MSTART;
      BS_RDA:  state_next = BS_WRA;
      BS_WRA:  state_next = b_ok ? BS_RDB : BS_ACC;
      BS_RDB:  state_next = BS_WRB;
      BS_WRB:  state_next = BS_ACC;
      BS_ACC:  state_next = BS_DONE;
      BS_DONE: if (!out_valid || results.ready) state_next = BS_IDLE;
      default: state_next = BS_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = cur.idx_a[AW-1:0];
    mem_wdata = '0;
    mul_start = 1'b0;
    pop_ready = 1'b0;
    out_load  = 1'b0;
    case (state)
      BS_INIT, BS_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      BS_IDLE:   pop_ready = 1'b1;
      BS_MSTART: mul_start = 1'b1;
      BS_WRA: begin
        mem_we    = 1'b1;
        mem_wdata = {clp_y[31:0], clp_x[31:0]};
      end
      BS_RDB: mem_addr = cur.idx_b[AW-1:0];
      BS_WRB: begin
        mem_we    = 1'b1;
        mem_addr  = cur.idx_b[AW-1:0];
        mem_wdata = {clp_y[31:0], clp_x[31:0]};
      end
      BS_DONE: out_load = !out_valid || results.ready;
      default: ;
    endcase
  end

  assign init_busy = (state == BS_INIT);

  // ---------------------------------------------------------------- force store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_INIT;
      clr_addr  <= '0;
      step      <= MS_DX2;
      energy    <= '0;
      virial    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        BS_INIT: clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
        BS_IDLE: begin
          if (pop_valid) begin
            cur  <= pop_item;
            sat  <= 1'b0;
            rfx  <= '0;
            rfy  <= '0;
            step <= MS_DX2;
            stat <= (pop_item.cmd == CMD_PAIR && pop_item.zero) ? STAT_ZERO : STAT_OK;
          end
        end
        BS_CLR: begin
          clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
          if (clr_last) begin
            energy <= '0;
            virial <= '0;
          end
        end
        BS_READ_W: begin
          rfx <= $signed(rd_data[31:0]);
          rfy <= $signed(rd_data[63:32]);
        end
        BS_MWAIT: begin
          if (mul_done) begin
            sat <= sat | mul_sat;
            case (step)
              MS_DX2: d2   <= mul_res[48:0];
              MS_DY2: d2   <= d2 + mul_res[48:0];
              MS_R2:  r2   <= mul_res[48:10];
              MS_U2:  u2   <= mul_res;
              MS_U3:  u3   <= mul_res;
              MS_U4:  u4   <= mul_res;
              MS_U6:  u6   <= mul_res;
              MS_U7:  u7   <= mul_res;
              MS_VE:  ve   <= mul_res;
              MS_M:   mm   <= mul_res;
              MS_DFM: dfm  <= mul_res;
              MS_FX:  fxm  <= mul_res;
              MS_FY:  fym  <= mul_res;
              MS_VIR: virm <= mul_res;
              default: ;
            endcase
            if (step != MS_VIR) begin
              step <= ljpf_mstep_t'(step + 1'b1);
            end
          end
        end
        BS_CUT: begin
          if (r2 >= {7'd0, cfg_regs.cutoff_r2}) begin
            stat <= STAT_CUT;
          end
          // 1/r2 in Q32.32 as 2^48 / max(r2, 1), one quotient bit a cycle
          dvs     <= (r2 == '0) ? 32'd1 : r2[31:0];
          div_rem <= '0;
          div_cnt <= 6'd48;
          u       <= '0;
        end
        BS_DIV: begin
          div_rem <= div_ge ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
          u       <= {u[47:0], div_ge};
          div_cnt <= div_cnt - 1'b1;
        end
        BS_WRA, BS_WRB: sat <= sat | ovf_x | ovf_y;
        BS_ACC: begin
          energy <= clp_e[47:0];
          virial <= clp_v[47:0];
          if (sat || ovf_e || ovf_v) begin
            stat <= STAT_SAT;
          end
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= stat;
      out_fx     <= rfx;
      out_fy     <= rfy;
      out_e      <= energy;
      out_v      <= virial;
    end
  end

  assign results.valid      = out_valid;
  assign results.status     = out_status;
  assign results.force_x    = out_fx;
  assign results.force_y    = out_fy;
  assign results.energy_sum = out_e;
  assign results.virial_sum = out_v;

endmodule

FILE: hdl/lennard_jones_pair_force_accumulator_top.sv
// Lennard-Jones pair force accumulator, 2-D periodic box.
// A pair runs 14 multiplies plus a bit-serial divide; one command in the back end at a time.
// Up to four commands queue behind the back end, results wait in an output register.
// Reset: synchronous; a sweep over min(NUM_PARTICLES, 8192) entries zeroes the force
// RAM, during which no command is taken (register writes are).
module lennard_jones_pair_force_accumulator_top import ljpf_pkg::*; #(
  parameter int NUM_PARTICLES = NUM_PARTICLES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ljpf_item_if.sink     items,
  ljpf_result_if.source results,
  ljpf_cfg_if.sink      cfg
);

  ljpf_cfg_t  cfg_regs;
  logic       init_busy;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  ljpf_item_t push_item, pop_item;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '{box_length: BOX_RST, inv_sigma_sq: INVSIG_RST,
                    cutoff_r2: CUTOFF_RST, bind_energy: EPS_RST};
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_BOX:    cfg_regs.box_length   <= cfg.data[23:0];
        REG_INVSIG: cfg_regs.inv_sigma_sq <= cfg.data;
        REG_CUTOFF: cfg_regs.cutoff_r2    <= cfg.data;
        REG_EPS:    cfg_regs.bind_energy  <= cfg.data[23:0];
        default: ;
      endcase
    end
  end

  ljpf_front u_front (
    .items      (items),
    .box_length (cfg_regs.box_length),
    .hold       (init_busy),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  ljpf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  ljpf_back #(.NUM_PARTICLES(NUM_PARTICLES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_regs  (cfg_regs),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .init_busy (init_busy),
    .results   (results)
  );

endmodule

FILE: tb/tb_lennard_jones_pair_force_accumulator_top.sv
// Testbench for the Lennard-Jones pair force accumulator: directed and random
// commands under several register settings, with a scoreboard that predicts every result.
// Depends on ljpf_pkg, ljpf_if and the top module lennard_jones_pair_force_accumulator_top.
module tb_lennard_jones_pair_force_accumulator_top;
  import ljpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPART = NUM_PARTICLES_DEF;

  typedef struct {
    bit [1:0]  cmd;
    bit [12:0] ia;
    bit [12:0] ib;
    bit [23:0] ax;
    bit [23:0] ay;
    bit [23:0] bx;
    bit [23:0] by;
  } lj_cmd_t;

  typedef struct {
    bit [1:0]  status;
    bit [31:0] fx;
    bit [31:0] fy;
    bit [47:0] esum;
    bit [47:0] vsum;
  } lj_result_t;

  class lj_scoreboard;
    bit [23:0] box_len = BOX_RST;
    bit [31:0] inv_sig = INVSIG_RST;
    bit [31:0] cutoff  = CUTOFF_RST;
    bit [23:0] eps     = EPS_RST;
    int        force_x_mem [NPART];
    int        force_y_mem [NPART];
    longint    energy_acc;
    longint    virial_acc;
    lj_result_t pending_results [$];
    int        errors;

    function void set_reg(bit [1:0] idx, bit [31:0] data);
      case (idx)
        REG_BOX:    box_len = data[23:0];
        REG_INVSIG: inv_sig = data;
        REG_CUTOFF: cutoff  = data;
        REG_EPS:    eps     = data[23:0];
        default: ;
      endcase
    endfunction

    // floor(a*b/2^32), saturating at 2^61
    function bit [63:0] mul_q32(bit [63:0] a, bit [63:0] b, inout bit sat);
      bit [63:0] ah, al, bh, bl, hh, r;
      ah = a >> 32; al = a & 64'hFFFF_FFFF;
      bh = b >> 32; bl = b & 64'hFFFF_FFFF;
      hh = ah * bh;
      if (hh >= (64'd1 << 30)) begin
        sat = 1;
        return 64'd1 << 61;
      end
      r = (hh << 32) + ah * bl + al * bh + ((al * bl) >> 32);
      if (r > (64'd1 << 61)) begin
        sat = 1;
        return 64'd1 << 61;
      end
      return r;
    endfunction

    function longint clamp_to(longint v, int bits, inout bit sat);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin sat = 1; return hi; end
      if (v < lo) begin sat = 1; return lo; end
      return v;
    endfunction

    function longint min_image(longint d);
      longint l;
      l = longint'({40'b0, box_len});
      if (2 * d > l) d -= l;
      else if (2 * d < -l) d += l;
      return d;
    endfunction

    function void add_force(bit [12:0] idx, longint fx, longint fy, inout bit sat);
      force_x_mem[idx] = int'(clamp_to(longint'(force_x_mem[idx]) + fx, 32, sat));
      force_y_mem[idx] = int'(clamp_to(longint'(force_y_mem[idx]) + fy, 32, sat));
    endfunction

    function bit [1:0] pair_update(lj_cmd_t c);
      bit sat, gneg, eneg;
      longint dx, dy, dfx, dfy, vij, vir;
      bit [63:0] adx, ady, d2, inv64, r2, u, u2, u3, u4, u6, u7, ve, m, dfm;
      sat = 0;
      dx = longint'({40'b0, c.ax}) - longint'({40'b0, c.bx});
      dy = longint'({40'b0, c.ay}) - longint'({40'b0, c.by});
      if (dx == 0 || dy == 0) return STAT_ZERO;
      dx = min_image(dx);
      dy = min_image(dy);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      d2 = adx * adx + ady * ady;
      inv64 = {32'b0, inv_sig};
      r2 = (((d2 >> 32) * inv64) + (((d2 & 64'hFFFF_FFFF) * inv64) >> 32)) >> 10;
      if (r2 >= {32'b0, cutoff}) return STAT_CUT;
      if (r2 == 0) r2 = 1;
      u  = (64'd1 << 48) / r2;
      u2 = mul_q32(u, u, sat);
      u3 = mul_q32(u2, u, sat);
      u4 = mul_q32(u2, u2, sat);
      u6 = mul_q32(u3, u3, sat);
      u7 = mul_q32(u6, u, sat);
      eneg = u6 < 2 * u3;
      ve = mul_q32({40'b0, eps}, eneg ? 2 * u3 - u6 : u6 - 2 * u3, sat);
      vij = eneg ? -longint'(ve) : longint'(ve);
      gneg = u7 < u4;
      m = mul_q32({40'b0, eps} * 64'd12, gneg ? u4 - u7 : u7 - u4, sat);
      dfm = mul_q32(m, inv64, sat);
      dfx = longint'(mul_q32(dfm, adx << 19, sat));
      dfy = longint'(mul_q32(dfm, ady << 19, sat));
      if (gneg != (dx < 0)) dfx = -dfx;
      if (gneg != (dy < 0)) dfy = -dfy;
      vir = longint'(mul_q32(dfm, d2 << 6, sat));
      if (gneg) vir = -vir;
      add_force(c.ia, dfx, dfy, sat);
      add_force(c.ib, -dfx, -dfy, sat);
      energy_acc = clamp_to(energy_acc + vij, 48, sat);
      virial_acc = clamp_to(virial_acc + vir, 48, sat);
      return sat ? STAT_SAT : STAT_OK;
    endfunction

    function void note_command(lj_cmd_t c);
      lj_result_t r;
      r = '{default: 0};
      case (c.cmd)
        CMD_CLEAR: begin
          foreach (force_x_mem[i]) begin
            force_x_mem[i] = 0;
            force_y_mem[i] = 0;
          end
          energy_acc = 0;
          virial_acc = 0;
        end
        CMD_PAIR: r.status = pair_update(c);
        CMD_READ: begin
          r.fx = force_x_mem[c.ia];
          r.fy = force_y_mem[c.ia];
        end
        default: ;
      endcase
      r.esum = energy_acc[47:0];
      r.vsum = virial_acc[47:0];
      pending_results = {pending_results, r};
    endfunction

    function void check_result(bit [1:0] status, bit [31:0] fx, bit [31:0] fy,
                               bit [47:0] esum, bit [47:0] vsum);
      lj_result_t e;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0d", status);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status); errors++;
      end
      if (fx !== e.fx) begin
        $error("force_x: expected %h, got %h", e.fx, fx); errors++;
      end
      if (fy !== e.fy) begin
        $error("force_y: expected %h, got %h", e.fy, fy); errors++;
      end
      if (esum !== e.esum) begin
        $error("energy_sum: expected %h, got %h", e.esum, esum); errors++;
      end
      if (vsum !== e.vsum) begin
        $error("virial_sum: expected %h, got %h", e.vsum, vsum); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  ljpf_item_if   item_ch ();
  ljpf_result_if res_ch ();
  ljpf_cfg_if    cfg_ch ();

  lennard_jones_pair_force_accumulator_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  lj_scoreboard sb = new();
  bit hold_req;
  int burst_left;
  bit no_gaps;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("lennard_jones_pair_force_accumulator_top: mismatch");
    $finish;
  end

  // receiver: stall pattern changes mode now and then; long hold-off on request
  initial begin
    int hold_left, mode, mode_left;
    hold_left = 0; mode = 0; mode_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.status, res_ch.force_x, res_ch.force_y,
                        res_ch.energy_sum, res_ch.virial_sum);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 400);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
        res_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom_range(0, 1));
          default: res_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_cmd(lj_cmd_t c);
    int gap;
    item_ch.valid   <= 1'b1;
    item_ch.cmd     <= c.cmd;
    item_ch.index_a <= c.ia;
    item_ch.index_b <= c.ib;
    item_ch.pos_ax  <= c.ax;
    item_ch.pos_ay  <= c.ay;
    item_ch.pos_bx  <= c.bx;
    item_ch.pos_by  <= c.by;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_command(c);
    burst_left--;
    if (burst_left <= 0 && !no_gaps) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(0, 3);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [31:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(bit [23:0] box, bit [31:0] inv, bit [31:0] cut, bit [23:0] e);
    write_reg(REG_BOX, {8'b0, box});
    write_reg(REG_INVSIG, inv);
    write_reg(REG_CUTOFF, cut);
    write_reg(REG_EPS, {8'b0, e});
  endtask

  function automatic lj_cmd_t mk(bit [1:0] cmd, bit [12:0] ia, bit [12:0] ib,
                                 bit [23:0] ax, bit [23:0] ay, bit [23:0] bx, bit [23:0] by);
    lj_cmd_t c;
    c = '{cmd, ia, ib, ax, ay, bx, by};
    return c;
  endfunction

  function automatic bit [12:0] pick_index();
    case ($urandom_range(0, 9))
      0: return 13'h1FFF;
      1: return 13'($urandom);
      default: return 13'($urandom_range(0, 15));
    endcase
  endfunction

  // partner coordinate near a, folded back into the box so the wrap gets exercised
  function automatic bit [23:0] near_pos(bit [23:0] a);
    int shifts [8] = '{4, 10, 14, 17, 18, 19, 20, 23};
    longint off, b, l;
    l = longint'({40'b0, sb.box_len});
    off = $urandom_range(0, 1 << shifts[$urandom_range(0, 7)]);
    if ($urandom_range(0, 1)) off = -off;
    b = longint'({40'b0, a}) + off;
    if (b < 0) b += l;
    else if (b >= l) b -= l;
    return b[23:0];
  endfunction

  function automatic lj_cmd_t random_cmd();
    lj_cmd_t c;
    int sel;
    sel = $urandom_range(0, 199);
    c.ia = pick_index();
    c.ib = ($urandom_range(0, 15) == 0) ? c.ia : pick_index();
    c.ax = 24'($urandom_range(0, sb.box_len - 1));
    c.ay = 24'($urandom_range(0, sb.box_len - 1));
    c.bx = near_pos(c.ax);
    c.by = near_pos(c.ay);
    if (sel < 2) c.cmd = CMD_CLEAR;
    else if (sel < 32) c.cmd = CMD_READ;
    else if (sel < 38) c.cmd = CMD_NOP;
    else c.cmd = CMD_PAIR;
    if (sel >= 180) begin
      // noise: fully random fields
      c.ax = 24'($urandom); c.ay = 24'($urandom); c.bx = 24'($urandom); c.by = 24'($urandom);
      c.ia = 13'($urandom); c.ib = 13'($urandom);
    end
    return c;
  endfunction

  initial begin
    lj_cmd_t c;
    rst = 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.cmd <= CMD_NOP;
    item_ch.index_a <= '0;
    item_ch.index_b <= '0;
    item_ch.pos_ax <= '0;
    item_ch.pos_ay <= '0;
    item_ch.pos_bx <= '0;
    item_ch.pos_by <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= REG_BOX;
    cfg_ch.data <= '0;
    hold_req = 0;
    no_gaps = 0;
    burst_left = 5;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_all(BOX_RST, INVSIG_RST, CUTOFF_RST, EPS_RST);

    // directed
    send_cmd(mk(CMD_NOP, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(CMD_READ, 13'h1FFF, 0, 0, 0, 0, 0));
    send_cmd(mk(CMD_PAIR, 1, 2, 24'd100000, 24'd5000, 24'd100000, 24'd9000));
    send_cmd(mk(CMD_PAIR, 1, 2, 24'd100000, 24'd5000, 24'd90000, 24'd5000));
    send_cmd(mk(CMD_PAIR, 1, 2, 24'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF));
    send_cmd(mk(CMD_PAIR, 1, 2, 24'd1000000, 24'd1000000, 24'd1200000, 24'd1100000));
    send_cmd(mk(CMD_PAIR, 3, 4, 24'd1000000, 24'd1000000, 24'd1000001, 24'd1000001));
    send_cmd(mk(CMD_PAIR, 0, 13'h1FFF, 24'd200000, 24'd300000, 24'd360000, 24'd200000));
    send_cmd(mk(CMD_PAIR, 5, 6, 24'd10000, 24'd20000, 24'd13050000, 24'd13000000));
    send_cmd(mk(CMD_PAIR, 6, 5, 24'd13050000, 24'd13000000, 24'd10000, 24'd20000));
    send_cmd(mk(CMD_PAIR, 7, 7, 24'd500000, 24'd500000, 24'd650000, 24'd600000));
    send_cmd(mk(CMD_READ, 1, 0, 0, 0, 0, 0));
    send_cmd(mk(CMD_READ, 3, 0, 0, 0, 0, 0));
    send_cmd(mk(CMD_READ, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(CMD_READ, 13'h1FFF, 0, 0, 0, 0, 0));
    send_cmd(mk(CMD_READ, 5, 0, 0, 0, 0, 0));
    send_cmd(mk(CMD_READ, 7, 0, 0, 0, 0, 0));
    send_cmd(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(CMD_READ, 3, 0, 0, 0, 0, 0));

    // receiver holds off while a gapless burst fills the block
    hold_req = 1;
    no_gaps = 1;
    repeat (25) send_cmd(random_cmd());
    no_gaps = 0;

    for (int phase = 0; phase < 5; phase++) begin
      drain_results();
      case (phase)
        1: write_all(24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF);
        2: write_all(24'd1, 32'd1, 32'd0, 24'd0);
        3: write_all(24'($urandom_range(1 << 20, 24'hFFFFFF)), $urandom | 1, $urandom,
                     24'($urandom));
        4: write_all(BOX_RST, INVSIG_RST * 4, 32'd3000000, 24'd100000);
        default: ;
      endcase
      repeat (185) send_cmd(random_cmd());
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("lennard_jones_pair_force_accumulator_top: match");
    end else begin
      $display("lennard_jones_pair_force_accumulator_top: mismatch");
    end
    $finish;
  end

endmodule
